// ===== sv/dcsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dcsp_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int ALPHA_BITS  = 16;
   localparam int KEY_BITS    = 8;
   localparam int LEVEL_BITS  = 6;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET = 16'd2621;
   localparam logic [SAMPLE_BITS-1:0] IDLE_RESET  = 10'd775;

   localparam logic [LEVEL_BITS-1:0] LEVEL_START  = 6'd25;
   localparam logic [LEVEL_BITS-1:0] LEVEL_SUM    = 6'd50;
   localparam logic [LEVEL_BITS-1:0] LEVEL_TOP    = 6'd33;
   localparam logic [LEVEL_BITS-1:0] LEVEL_BOTTOM = 6'd17;
   localparam int DRIVE_STEP = 31;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_KEY    = 1'b1;

   localparam logic [KEY_BITS-1:0] KEY_M_LOWER = 8'h6D;
   localparam logic [KEY_BITS-1:0] KEY_M_UPPER = 8'h4D;
   localparam logic [KEY_BITS-1:0] KEY_A_LOWER = 8'h61;
   localparam logic [KEY_BITS-1:0] KEY_A_UPPER = 8'h41;
   localparam logic [KEY_BITS-1:0] KEY_D_LOWER = 8'h64;
   localparam logic [KEY_BITS-1:0] KEY_D_UPPER = 8'h44;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE  = 1'd1;

   typedef struct packed {
      logic                   op;
      logic [SAMPLE_BITS-1:0] sample_a;
      logic [SAMPLE_BITS-1:0] sample_b;
      logic [KEY_BITS-1:0]    key_code;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] drive_a;
      logic [SAMPLE_BITS-1:0] drive_b;
      logic                   manual_active;
   } rsp_type;

   typedef struct packed {
      logic                take;
      logic                op;
      logic [KEY_BITS-1:0] key_code;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== sv/dcsp_ema_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcsp_ema_lane #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             update,
   input  wire logic [dcsp_pkg::ALPHA_BITS-1:0]  alpha,
   input  wire logic [dcsp_pkg::SAMPLE_BITS-1:0] idle_level,
   input  wire logic [dcsp_pkg::SAMPLE_BITS-1:0] sample,
   output logic      [dcsp_pkg::SAMPLE_BITS-1:0] drive
);
   import dcsp_pkg::*;

   localparam int AvgBits = SAMPLE_BITS + FRACTION_BITS;

   logic        [AvgBits-1:0]            smooth_ff;
   logic        [AvgBits-1:0]            smooth_in;
   logic signed [AvgBits:0]              diff;
   logic signed [AvgBits+ALPHA_BITS+1:0] product;
   logic signed [AvgBits+1:0]            delta;
   logic signed [AvgBits+1:0]            sum;

   assign diff    = $signed({1'b0, sample, {FRACTION_BITS{1'b0}}})
                  - $signed({1'b0, smooth_ff});
   assign product = $signed({1'b0, alpha}) * diff;
   assign delta   = $signed(product[ALPHA_BITS +: AvgBits+2]);
   assign sum     = $signed({2'b00, smooth_ff}) + delta;
   assign smooth_in = sum[AvgBits-1:0];

   assign drive = (sample != '0) ? smooth_in[AvgBits-1 -: SAMPLE_BITS] : idle_level;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= {IDLE_RESET, {FRACTION_BITS{1'b0}}};
      end else if (update) begin
         smooth_ff <= smooth_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/dcsp_mode_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dcsp_mode_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire dcsp_pkg::ctrl_type               ctrl,
   input  wire logic [dcsp_pkg::SAMPLE_BITS-1:0] lane_drive_a,
   input  wire logic [dcsp_pkg::SAMPLE_BITS-1:0] lane_drive_b,
   output logic                                  lane_update,
   output dcsp_pkg::rsp_type                     result
);
   import dcsp_pkg::*;

   logic                   mode_ff,    mode_in;
   logic [LEVEL_BITS-1:0]  level_ff,   level_in;
   logic [LEVEL_BITS-1:0]  level_base;
   logic [SAMPLE_BITS-1:0] held_a_ff,  held_a_in;
   logic [SAMPLE_BITS-1:0] held_b_ff,  held_b_in;
   logic                   toggle;

   function automatic logic [SAMPLE_BITS-1:0] level_drive(input logic [LEVEL_BITS-1:0] lvl);
      logic [SAMPLE_BITS:0] wide;
      wide = {{(SAMPLE_BITS+1-LEVEL_BITS){1'b0}}, lvl};
      wide = (wide << 5) - wide;
      return wide[SAMPLE_BITS-1:0];
   endfunction

   assign lane_update = ctrl.take && (ctrl.op == OP_SAMPLE) && mode_ff;

   always_comb begin
      toggle = 1'b0;
      case (ctrl.key_code) inside
         KEY_M_LOWER, KEY_M_UPPER: toggle = 1'b1;
         default:                  toggle = 1'b0;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      level_in   = level_ff;
      level_base = level_ff;
      held_a_in  = held_a_ff;
      held_b_in  = held_b_ff;
      if (ctrl.take && ctrl.op == OP_KEY) begin
         mode_in = mode_ff ^ toggle;
         if (!mode_in) begin
            if (toggle) begin
               level_base = LEVEL_START;
            end
            level_in = level_base;
            case (ctrl.key_code) inside
               KEY_A_LOWER, KEY_A_UPPER: begin
                  if (level_base < LEVEL_TOP) level_in = level_base + LEVEL_BITS'(1);
               end
               KEY_D_LOWER, KEY_D_UPPER: begin
                  if (level_base > LEVEL_BOTTOM) level_in = level_base - LEVEL_BITS'(1);
               end
               default: level_in = level_base;
            endcase
            held_a_in = level_drive(level_in);
            held_b_in = level_drive(LEVEL_SUM - level_in);
         end
      end else if (lane_update) begin
         held_a_in = lane_drive_a;
         held_b_in = lane_drive_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b1;
         level_ff  <= LEVEL_START;
         held_a_ff <= IDLE_RESET;
         held_b_ff <= IDLE_RESET;
      end else begin
         mode_ff   <= mode_in;
         level_ff  <= level_in;
         held_a_ff <= held_a_in;
         held_b_ff <= held_b_in;
      end
   end

   assign result.drive_a       = held_a_ff;
   assign result.drive_b       = held_b_ff;
   assign result.manual_active = mode_ff;

endmodule

`default_nettype wire

// ===== sv/dual_channel_smoothing_passthrough_unit.sv =====
// A result appears on rsp in the cycle after its request beat is taken.
// Throughput: one request per clock when not stalled; each lane closes its average
// feedback via one multiply-add per cycle; the output register parts the channels.
// Reset (synchronous, active high): manual mode, level 25, both drives and
// averages at the idle level 775, alpha 2621, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_smoothing_passthrough_unit #(
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire dcsp_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output dcsp_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dcsp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [dcsp_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import dcsp_pkg::*;

   logic [ALPHA_BITS-1:0]  alpha_ff,  alpha_in;
   logic [SAMPLE_BITS-1:0] idle_ff,   idle_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic [SAMPLE_BITS-1:0] lane_drive_a;
   logic [SAMPLE_BITS-1:0] lane_drive_b;
   logic                   lane_update;
   ctrl_type               ctrl;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   assign ctrl.take     = accept;
   assign ctrl.op       = req_data.op;
   assign ctrl.key_code = req_data.key_code;

   always_comb begin
      alpha_in = alpha_ff;
      idle_in  = idle_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_in = csr_data[ALPHA_BITS-1:0];
            CSR_IDLE:  idle_in  = csr_data[SAMPLE_BITS-1:0];
            default:   alpha_in = alpha_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= ALPHA_RESET;
         idle_ff      <= IDLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         alpha_ff     <= alpha_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   dcsp_ema_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_a (
      .clock      (clock),
      .reset      (reset),
      .update     (lane_update),
      .alpha      (alpha_ff),
      .idle_level (idle_ff),
      .sample     (req_data.sample_a),
      .drive      (lane_drive_a)
   );

   dcsp_ema_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_b (
      .clock      (clock),
      .reset      (reset),
      .update     (lane_update),
      .alpha      (alpha_ff),
      .idle_level (idle_ff),
      .sample     (req_data.sample_b),
      .drive      (lane_drive_b)
   );

   dcsp_mode_ctrl u_mode_ctrl (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .lane_drive_a (lane_drive_a),
      .lane_drive_b (lane_drive_b),
      .lane_update  (lane_update),
      .result       (rsp_data)
   );

   a_accept_gives_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted request produced no result beat");

   a_keyboard_levels_sum: assert property (@(posedge clock) disable iff (reset)
      !rsp_data.manual_active |->
         ({1'b0, rsp_data.drive_a} + {1'b0, rsp_data.drive_b})
            == 11'(int'(LEVEL_SUM) * DRIVE_STEP))
      else $error("keyboard drives do not sum to full scale");

   a_zero_reading_idles: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.op == OP_SAMPLE && rsp_data.manual_active
         && req_data.sample_a == '0 |=> rsp_data.drive_a == $past(idle_ff))
      else $error("zero reading did not drive the idle level");

endmodule

`default_nettype wire
